>>> hw/rtl/assert_macros.svh
// Assertion helpers; the enclosing scope supplies clk_i and rst_ni.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define LWQ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

`define LWQ_ASSERT_NEVER(label, expr, msg) \
  `LWQ_ASSERT(label, !(expr), msg)

`endif

>>> hw/rtl/lwq_pkg.sv
package lwq_pkg;

  localparam int unsigned PROB_ONE = 65536;
  localparam int unsigned DENOM    = 196608;  // 3 * 65536
  localparam int unsigned RECIP3   = 683;     // ceil(2^11 / 3)

  localparam int VALUE_W = 32;
  localparam int PIDX_W  = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;
  localparam int LAG_W    = 6;
  localparam int WEIGHT_W = 16;
  localparam int PROB_W   = 17;
  localparam int REM_W    = 18;
  localparam int NUM_W    = 21;
  localparam int CNT_W    = 3;
  localparam int NREG_PROB = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TAP_COUNT    = 3'd0,
    REG_LAG_WORDS    = 3'd1,
    REG_WEIGHT_WORDS = 3'd2,
    REG_PROB_COUNT   = 3'd3,
    REG_PROB_0       = 3'd4,
    REG_PROB_1       = 3'd5,
    REG_PROB_2       = 3'd6,
    REG_PROB_3       = 3'd7
  } reg_idx_e;

endpackage

>>> hw/rtl/lwq_in_if.sv
interface lwq_in_if #(
  parameter int SampleBits = 16
) ();
  logic                         valid;
  logic                         ready;
  logic signed [SampleBits-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

>>> hw/rtl/lwq_out_if.sv
interface lwq_out_if import lwq_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] quantile_value;
  logic                      available;
  logic [PIDX_W-1:0]         prob_index;
  logic                      last;

  modport source (output valid, output quantile_value, output available,
                  output prob_index, output last, input ready);
  modport sink   (input valid, input quantile_value, input available,
                  input prob_index, input last, output ready);
endinterface

>>> hw/rtl/lagged_weighted_quantile_top.sv
// Sequence: with history, each active tap is read, weighted and written back, the taps are
//   sorted, and each result is interpolated, divided by three bytewise, summed and presented;
//   without history, each result is presented as unavailable with no computation.
// Throughput: one sample at a time; input is ready again in the cycle after the last word leaves.
//   Tap weighting and interpolation products share one multiplier; the delay line is one RAM read port.
// Reset: registers take their documented defaults, history count and pointer clear;
//   the delay line is not cleared, since missing history forces unavailable results.
module lagged_weighted_quantile_top import lwq_pkg::*; #(
  parameter int TAPS        = 4,
  parameter int MAX_LAG     = 64,
  parameter int PROBS       = 4,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  lwq_in_if.sink                in_ch,
  lwq_out_if.source             out_ch,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int PW  = SAMPLE_BITS + WEIGHT_W;
  localparam int MA  = PW + 1;
  localparam int MB  = REM_W + 1;
  localparam int MW  = MA + MB;
  localparam int NCH = (PW + 2 + 7) / 8;
  localparam int YW  = NCH * 8;
  localparam int XW  = (PW > VALUE_W) ? PW : VALUE_W;
  localparam int AW  = $clog2(MAX_LAG);
  localparam int SW  = $clog2(MAX_LAG + 1);
  localparam int TIW = (TAPS > 1) ? $clog2(TAPS) : 1;
  localparam int PIW = (PROBS > 1) ? $clog2(PROBS) : 1;
  localparam int DCW = (NCH > 1) ? $clog2(NCH) : 1;

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_RD   = 4'd1;
  localparam logic [3:0] ST_MUL  = 4'd2;
  localparam logic [3:0] ST_WB   = 4'd3;
  localparam logic [3:0] ST_SORT = 4'd4;
  localparam logic [3:0] ST_QSET = 4'd5;
  localparam logic [3:0] ST_QMUL = 4'd6;
  localparam logic [3:0] ST_DLD  = 4'd7;
  localparam logic [3:0] ST_DIV  = 4'd8;
  localparam logic [3:0] ST_SUM  = 4'd9;
  localparam logic [3:0] ST_OUT  = 4'd10;

  localparam logic signed [PW-1:0] PAD_MAX = {1'b0, {(PW-1){1'b1}}};

  // configuration
  logic [CNT_W-1:0]    tap_count_q;
  logic [4*LAG_W-1:0]  lag_words_q;
  logic [63:0]         weight_words_q;
  logic [CNT_W-1:0]    prob_count_q;
  logic [PROB_W-1:0]   prob_q [NREG_PROB];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tap_count_q    <= CNT_W'(4);
      lag_words_q    <= '0;
      weight_words_q <= 64'h0100_0100_0100_0100;
      prob_count_q   <= CNT_W'(1);
      prob_q[0]      <= PROB_W'(32768);
      prob_q[1]      <= '0;
      prob_q[2]      <= '0;
      prob_q[3]      <= '0;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_index_i))
        REG_TAP_COUNT:    tap_count_q    <= cfg_data_i[CNT_W-1:0];
        REG_LAG_WORDS:    lag_words_q    <= cfg_data_i[4*LAG_W-1:0];
        REG_WEIGHT_WORDS: weight_words_q <= cfg_data_i;
        REG_PROB_COUNT:   prob_count_q   <= cfg_data_i[CNT_W-1:0];
        REG_PROB_0:       prob_q[0]      <= cfg_data_i[PROB_W-1:0];
        REG_PROB_1:       prob_q[1]      <= cfg_data_i[PROB_W-1:0];
        REG_PROB_2:       prob_q[2]      <= cfg_data_i[PROB_W-1:0];
        REG_PROB_3:       prob_q[3]      <= cfg_data_i[PROB_W-1:0];
        default: ;
      endcase
    end
  end

  // control and data registers
  logic [3:0]             state_q, state_d;
  logic [AW-1:0]          wp_q, wp_d;
  logic [SW-1:0]          seen_q, seen_d;
  logic [TIW-1:0]         k_q, k_d;
  logic [TIW-1:0]         n_m1_q, n_m1_d;
  logic [CNT_W-1:0]       n_q, n_d;
  logic [TIW-1:0]         sidx_q, sidx_d;
  logic [TIW-1:0]         spass_q, spass_d;
  logic [PIW-1:0]         i_q, i_d;
  logic [PIW-1:0]         np_m1_q, np_m1_d;
  logic [DCW-1:0]         dcnt_q, dcnt_d;
  logic                   avail_q, avail_d;
  logic signed [PW-1:0]   v_q [TAPS];
  logic signed [PW-1:0]   v_d [TAPS];
  logic signed [PW-1:0]   a_q, a_d;
  logic [PW-1:0]          diff_q, diff_d;
  logic [REM_W-1:0]       rem_q, rem_d;
  logic [YW-1:0]          y_q, y_d;
  logic [YW-1:0]          quot_q, quot_d;
  logic [1:0]             r_q, r_d;
  logic [VALUE_W-1:0]     out_val_q, out_val_d;

  // shared datapath signals
  logic [SAMPLE_BITS-1:0] rdata;
  logic [AW-1:0]          raddr;
  logic signed [MA-1:0]   mul_a;
  logic signed [MB-1:0]   mul_b;
  logic signed [MW-1:0]   prod;
  logic                   in_acc;

  assign in_acc = in_ch.valid && in_ch.ready;

  lwq_ram #(
    .Width (SAMPLE_BITS),
    .Depth (MAX_LAG)
  ) u_lwq_ram (
    .clk_i   (clk_i),
    .we_i    (in_acc),
    .waddr_i (wp_q),
    .wdata_i (in_ch.sample),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  lwq_mul #(
    .AWidth (MA),
    .BWidth (MB)
  ) u_lwq_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  // tap lag lookup and active counts
  logic [LAG_W-1:0] lag_sat [4];
  logic [LAG_W-1:0] maxlag;
  logic [CNT_W-1:0] n_cl;
  logic [CNT_W-1:0] np_cl;

  always_comb begin
    n_cl = tap_count_q;
    if (tap_count_q == '0) n_cl = CNT_W'(1);
    else if (tap_count_q > CNT_W'(TAPS)) n_cl = CNT_W'(TAPS);
    np_cl = prob_count_q;
    if (prob_count_q == '0) np_cl = CNT_W'(1);
    else if (prob_count_q > CNT_W'(PROBS)) np_cl = CNT_W'(PROBS);
    maxlag = '0;
    for (int t = 0; t < 4; t++) begin
      lag_sat[t] = lag_words_q[LAG_W*t +: LAG_W];
      if (lag_sat[t] > LAG_W'(MAX_LAG - 1)) lag_sat[t] = LAG_W'(MAX_LAG - 1);
      if ((CNT_W'(t) < n_cl) && (lag_sat[t] > maxlag)) maxlag = lag_sat[t];
    end
  end

  logic [LAG_W-1:0] cur_lag;
  logic [AW-1:0]    cur_lag_a;

  always_comb begin
    cur_lag   = lag_sat[2'(k_q)];
    cur_lag_a = cur_lag[AW-1:0];
    if (wp_q >= cur_lag_a) raddr = wp_q - cur_lag_a;
    else raddr = AW'((AW+1)'(wp_q) + (AW+1)'(MAX_LAG) - (AW+1)'(cur_lag_a));
  end

  // interpolation setup for the current probability
  logic [PROB_W-1:0] p_sat;
  logic [3:0]        coef;
  logic [NUM_W-1:0]  num;
  logic [2:0]        jj;
  logic [2:0]        ia, ib;
  logic [NUM_W-1:0]  jbase;

  always_comb begin
    p_sat = prob_q[2'(i_q)];
    if (p_sat > PROB_W'(PROB_ONE)) p_sat = PROB_W'(PROB_ONE);
    coef = 4'(3 * n_q) + 4'd1;
    num  = NUM_W'(p_sat) * NUM_W'(coef) + NUM_W'(PROB_ONE);
    jj   = '0;
    for (int t = 1; t <= 4; t++) begin
      if (num >= NUM_W'(t * DENOM)) jj = 3'(t);
    end
    case (jj)
      3'd1:    jbase = NUM_W'(DENOM);
      3'd2:    jbase = NUM_W'(2 * DENOM);
      3'd3:    jbase = NUM_W'(3 * DENOM);
      3'd4:    jbase = NUM_W'(4 * DENOM);
      default: jbase = '0;
    endcase
    ia = (jj == '0) ? 3'd0 : jj - 3'd1;
    if (ia > 3'(n_m1_q)) ia = 3'(n_m1_q);
    ib = jj;
    if (ib > 3'(n_m1_q)) ib = 3'(n_m1_q);
  end

  // divide-by-three digit step, one byte per cycle
  logic [9:0]  dt;
  logic [20:0] dprod;
  logic [7:0]  dq;
  logic [9:0]  dr;

  always_comb begin
    dt    = {r_q, y_q[YW-1 -: 8]};
    dprod = 21'(dt) * 21'(RECIP3);
    dq    = dprod[18:11];
    dr    = dt - 10'(3 * dq);
  end

  always_comb begin
    mul_a = MA'(signed'(rdata));
    mul_b = MB'(signed'(weight_words_q[WEIGHT_W*2'(k_q) +: WEIGHT_W]));
    if (state_q == ST_QMUL) begin
      mul_a = signed'({1'b0, diff_q});
      mul_b = signed'({1'b0, rem_q});
    end
  end

  always_comb begin
    state_d   = state_q;
    wp_d      = wp_q;
    seen_d    = seen_q;
    k_d       = k_q;
    n_m1_d    = n_m1_q;
    n_d       = n_q;
    sidx_d    = sidx_q;
    spass_d   = spass_q;
    i_d       = i_q;
    np_m1_d   = np_m1_q;
    dcnt_d    = dcnt_q;
    avail_d   = avail_q;
    v_d       = v_q;
    a_d       = a_q;
    diff_d    = diff_q;
    rem_d     = rem_q;
    y_d       = y_q;
    quot_d    = quot_q;
    r_d       = r_q;
    out_val_d = out_val_q;

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          n_d     = n_cl;
          n_m1_d  = TIW'(n_cl - CNT_W'(1));
          np_m1_d = PIW'(np_cl - CNT_W'(1));
          avail_d = (7'(seen_q) >= 7'(maxlag));
          k_d     = '0;
          i_d     = '0;
          for (int t = 0; t < TAPS; t++) v_d[t] = PAD_MAX;
          out_val_d = '0;
          state_d = (7'(seen_q) >= 7'(maxlag)) ? ST_RD : ST_OUT;
        end
      end
      ST_RD:  state_d = ST_MUL;
      ST_MUL: state_d = ST_WB;
      ST_WB: begin
        v_d[k_q] = prod[PW-1:0];
        if (k_q == n_m1_q) begin
          sidx_d  = '0;
          spass_d = '0;
          state_d = (TAPS > 1) ? ST_SORT : ST_QSET;
        end else begin
          k_d     = k_q + TIW'(1);
          state_d = ST_RD;
        end
      end
      ST_SORT: begin
        // padded entries hold the maximum, so the full bubble over TAPS is safe
        if (v_q[sidx_q] > v_q[TIW'(sidx_q + TIW'(1))]) begin
          v_d[sidx_q]                  = v_q[TIW'(sidx_q + TIW'(1))];
          v_d[TIW'(sidx_q + TIW'(1))] = v_q[sidx_q];
        end
        if (sidx_q == TIW'(TAPS - 2)) begin
          sidx_d = '0;
          if (spass_q == TIW'(TAPS - 2)) state_d = ST_QSET;
          else spass_d = spass_q + TIW'(1);
        end else begin
          sidx_d = sidx_q + TIW'(1);
        end
      end
      ST_QSET: begin
        a_d     = v_q[TIW'(ia)];
        diff_d  = PW'(v_q[TIW'(ib)] - v_q[TIW'(ia)]);
        rem_d   = REM_W'(num - jbase);
        state_d = ST_QMUL;
      end
      ST_QMUL: state_d = ST_DLD;
      ST_DLD: begin
        // drop the 2^16 part of the denominator here; the divide by three follows
        y_d     = YW'(prod[PW+17:16]);
        quot_d  = '0;
        r_d     = '0;
        dcnt_d  = DCW'(NCH - 1);
        state_d = ST_DIV;
      end
      ST_DIV: begin
        y_d    = y_q << 8;
        quot_d = {quot_q[YW-9:0], dq};
        r_d    = dr[1:0];
        if (dcnt_q == '0) state_d = ST_SUM;
        else dcnt_d = dcnt_q - DCW'(1);
      end
      ST_SUM: begin
        out_val_d = VALUE_W'(XW'(a_q) + XW'(quot_q));
        state_d   = ST_OUT;
      end
      ST_OUT: begin
        if (out_ch.ready) begin
          if (i_q == np_m1_q) begin
            wp_d    = (wp_q == AW'(MAX_LAG - 1)) ? '0 : wp_q + AW'(1);
            if (seen_q < SW'(MAX_LAG)) seen_d = seen_q + SW'(1);
            state_d = ST_IDLE;
          end else begin
            i_d     = i_q + PIW'(1);
            state_d = avail_q ? ST_QSET : ST_OUT;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      wp_q    <= '0;
      seen_q  <= '0;
      k_q     <= '0;
      n_m1_q  <= '0;
      n_q     <= CNT_W'(1);
      sidx_q  <= '0;
      spass_q <= '0;
      i_q     <= '0;
      np_m1_q <= '0;
      dcnt_q  <= '0;
      avail_q <= 1'b0;
    end else begin
      state_q <= state_d;
      wp_q    <= wp_d;
      seen_q  <= seen_d;
      k_q     <= k_d;
      n_m1_q  <= n_m1_d;
      n_q     <= n_d;
      sidx_q  <= sidx_d;
      spass_q <= spass_d;
      i_q     <= i_d;
      np_m1_q <= np_m1_d;
      dcnt_q  <= dcnt_d;
      avail_q <= avail_d;
    end
  end

  always_ff @(posedge clk_i) begin
    v_q       <= v_d;
    a_q       <= a_d;
    diff_q    <= diff_d;
    rem_q     <= rem_d;
    y_q       <= y_d;
    quot_q    <= quot_d;
    r_q       <= r_d;
    out_val_q <= out_val_d;
  end

  assign in_ch.ready           = (state_q == ST_IDLE);
  assign out_ch.valid          = (state_q == ST_OUT);
  assign out_ch.quantile_value = signed'(out_val_q);
  assign out_ch.available      = avail_q;
  assign out_ch.prob_index     = PIDX_W'(i_q);
  assign out_ch.last           = (i_q == np_m1_q);

endmodule

>>> hw/rtl/lwq_ram.sv
module lwq_ram #(
  parameter int Width = 16,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> hw/rtl/lwq_mul.sv
module lwq_mul #(
  parameter int AWidth = 17,
  parameter int BWidth = 19
) (
  input  logic                            clk_i,
  input  logic signed [AWidth-1:0]        a_i,
  input  logic signed [BWidth-1:0]        b_i,
  output logic signed [AWidth+BWidth-1:0] p_o
);

  logic signed [AWidth+BWidth-1:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= a_i * b_i;
  end

  assign p_o = p_q;

endmodule

>>> hw/rtl/lwq_checker.sv
`include "assert_macros.svh"

module lwq_checker import lwq_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_i,
  input logic               out_valid_i,
  input logic               out_ready_i,
  input logic               out_available_i,
  input logic               out_last_i,
  input logic [VALUE_W-1:0] out_value_i
);

  `LWQ_ASSERT(a_out_hold, out_valid_i && !out_ready_i |=> out_valid_i, "result word dropped")
  `LWQ_ASSERT_NEVER(a_one_side, in_ready_i && out_valid_i, "input taken while result pending")
  `LWQ_ASSERT(a_na_zero, out_valid_i && !out_available_i |-> out_value_i == '0, "NA not zero")
  `LWQ_ASSERT(a_busy, in_valid_i && in_ready_i |=> !in_ready_i, "ready after accept")
  `LWQ_ASSERT(a_free, out_valid_i && out_ready_i && out_last_i |=> in_ready_i, "stuck after last")

endmodule

bind lagged_weighted_quantile_top lwq_checker u_lwq_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_ch.valid),
  .in_ready_i      (in_ch.ready),
  .out_valid_i     (out_ch.valid),
  .out_ready_i     (out_ch.ready),
  .out_available_i (out_ch.available),
  .out_last_i      (out_ch.last),
  .out_value_i     (out_ch.quantile_value)
);
